FILE: hw/rtl/dcr_pkg.sv
`timescale 1ns / 1ps

package dcr_pkg;

  // Item modes
  localparam logic [1:0] MODE_READ     = 2'd0;
  localparam logic [1:0] MODE_WRITE    = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;
  localparam logic [1:0] MODE_ERROR    = 2'd3;

  // Per-channel register selects (offset bits 3..0)
  localparam logic [3:0] REG_ADDR  = 4'h0;
  localparam logic [3:0] REG_BLOCK = 4'h4;
  localparam logic [3:0] REG_CTRL  = 4'h8;

  // Main register offsets
  localparam logic [6:0] OFF_PRIORITY = 7'h70;
  localparam logic [6:0] OFF_DICR     = 7'h74;

  localparam int          DEF_NUM_CHANNELS = 7;
  localparam int          IRQ_W            = 7;
  localparam int          SPARE_W          = 6;
  localparam int          ADDR_W           = 24;
  localparam int          CTRL_W           = 13;
  localparam logic [31:0] PRIORITY_RESET   = 32'h0765_4321;

  // Bit positions inside the packed control word
  localparam int CB_SYNC_LO = 3;
  localparam int CB_SYNC_HI = 4;
  localparam int CB_EN      = 11;
  localparam int CB_TRIG    = 12;

  // One item as seen by the register modules
  typedef struct packed {
    logic        exec;
    logic [1:0]  mode;
    logic [6:0]  offset;
    logic [31:0] wdata;
    logic [2:0]  evch;
  } dcr_op_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        started;
    logic        cancel;
  } dcr_chan_res_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        line;
    logic        raise;
    logic        drop;
  } dcr_irq_res_t;

  // Keep only the implemented control bits, packed
  function automatic logic [CTRL_W-1:0] ctrl_pack(input logic [31:0] v);
    return {v[28], v[24], v[22:20], v[18:16], v[10:9], v[8], v[1], v[0]};
  endfunction

  // Place packed control bits back at their bus positions
  function automatic logic [31:0] ctrl_unpack(input logic [CTRL_W-1:0] c);
    logic [31:0] r;
    r        = '0;
    r[0]     = c[0];
    r[1]     = c[1];
    r[8]     = c[2];
    r[10:9]  = c[4:3];
    r[18:16] = c[7:5];
    r[22:20] = c[10:8];
    r[24]    = c[11];
    r[28]    = c[12];
    return r;
  endfunction

endpackage

FILE: hw/rtl/dcr_chan_regs.sv
`timescale 1ns / 1ps

module dcr_chan_regs #(
  parameter int NUM_CHANNELS = dcr_pkg::DEF_NUM_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dcr_pkg::dcr_op_t      op,
  output dcr_pkg::dcr_chan_res_t res
);
  import dcr_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [ADDR_W-1:0] addr_r  [NUM_CHANNELS];
  logic [15:0]       size_r  [NUM_CHANNELS];
  logic [15:0]       count_r [NUM_CHANNELS];
  logic [CTRL_W-1:0] ctrl_r  [NUM_CHANNELS];

  logic [2:0]        ch;
  logic [3:0]        reg_sel;
  logic              hit;
  logic [CH_W-1:0]   ch_idx;
  logic [CTRL_W-1:0] sel_ctrl;
  logic [CTRL_W-1:0] ctrl_wr;
  logic              active;
  logic              is_wr;

  assign ch      = op.offset[6:4];
  assign reg_sel = op.offset[3:0];
  assign hit     = (32'(ch) < NUM_CHANNELS);
  assign ch_idx  = op.offset[4 +: CH_W];
  assign is_wr   = op.exec && (op.mode == MODE_WRITE) && hit;

  // Control write: sync code three keeps the old sync field
  always_comb begin
    sel_ctrl = hit ? ctrl_r[ch_idx] : '0;
    ctrl_wr  = ctrl_pack(op.wdata);
    if (ctrl_wr[CB_SYNC_HI:CB_SYNC_LO] == 2'b11) begin
      ctrl_wr[CB_SYNC_HI:CB_SYNC_LO] = sel_ctrl[CB_SYNC_HI:CB_SYNC_LO];
    end
    active = ctrl_wr[CB_EN] &&
             ((ctrl_wr[CB_SYNC_HI:CB_SYNC_LO] != 2'b00) || ctrl_wr[CB_TRIG]);
  end

  // Per-channel storage
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
    logic sel_i;
    logic done_i;
    assign sel_i  = is_wr && (ch == 3'(i));
    assign done_i = op.exec && (op.mode == MODE_COMPLETE) && (op.evch == 3'(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        addr_r[i]  <= '0;
        size_r[i]  <= '0;
        count_r[i] <= '0;
        ctrl_r[i]  <= '0;
      end else if (sel_i) begin
        unique case (reg_sel)
          REG_ADDR: addr_r[i] <= op.wdata[ADDR_W-1:0];
          REG_BLOCK: begin
            size_r[i]  <= op.wdata[15:0];
            count_r[i] <= op.wdata[31:16];
          end
          REG_CTRL: ctrl_r[i] <= ctrl_wr;
          default: ;
        endcase
      end else if (done_i) begin
        // completion stops the channel
        ctrl_r[i][CB_EN]   <= 1'b0;
        ctrl_r[i][CB_TRIG] <= 1'b0;
      end
    end
  end

  // Read mux and control-write flags
  always_comb begin
    res = '0;
    if (op.exec && hit) begin
      if (op.mode == MODE_READ) begin
        unique case (reg_sel)
          REG_ADDR:  res.rdata = {{(32 - ADDR_W){1'b0}}, addr_r[ch_idx]};
          REG_BLOCK: res.rdata = {count_r[ch_idx], size_r[ch_idx]};
          REG_CTRL:  res.rdata = ctrl_unpack(sel_ctrl);
          default:   res.rdata = '0;
        endcase
      end else if ((op.mode == MODE_WRITE) && (reg_sel == REG_CTRL)) begin
        res.started = active;
        res.cancel  = !active && (ch < 3'd3);
      end
    end
  end

endmodule

FILE: hw/rtl/dcr_irq_regs.sv
`timescale 1ns / 1ps

module dcr_irq_regs #(
  parameter int NUM_CHANNELS = dcr_pkg::DEF_NUM_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dcr_pkg::dcr_op_t     op,
  output dcr_pkg::dcr_irq_res_t res
);
  import dcr_pkg::*;

  logic [31:0]        prio_r, prio_nxt;
  logic [SPARE_W-1:0] spare_r, spare_nxt;
  logic               force_r, force_nxt;
  logic [IRQ_W-1:0]   en_r, en_nxt;
  logic               men_r, men_nxt;
  logic [IRQ_W-1:0]   pend_r, pend_nxt;
  logic               flag_r, flag_nxt;

  // Next state of the main registers
  always_comb begin
    prio_nxt  = prio_r;
    spare_nxt = spare_r;
    force_nxt = force_r;
    en_nxt    = en_r;
    men_nxt   = men_r;
    pend_nxt  = pend_r;
    if (op.exec) begin
      unique case (op.mode)
        MODE_WRITE: begin
          if (op.offset == OFF_PRIORITY) begin
            prio_nxt = op.wdata;
          end else if (op.offset == OFF_DICR) begin
            spare_nxt = op.wdata[SPARE_W-1:0];
            force_nxt = op.wdata[15];
            en_nxt    = op.wdata[22:16];
            men_nxt   = op.wdata[23];
            pend_nxt  = pend_r & ~op.wdata[30:24];
          end
        end
        MODE_COMPLETE: begin
          if ((32'(op.evch) < NUM_CHANNELS) && en_r[op.evch]) begin
            pend_nxt[op.evch] = 1'b1;
          end
        end
        MODE_ERROR: force_nxt = 1'b1;
        default: ;
      endcase
    end
    flag_nxt = force_nxt | (men_nxt & (|pend_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r  <= PRIORITY_RESET;
      spare_r <= '0;
      force_r <= 1'b0;
      en_r    <= '0;
      men_r   <= 1'b0;
      pend_r  <= '0;
      flag_r  <= 1'b0;
    end else begin
      prio_r  <= prio_nxt;
      spare_r <= spare_nxt;
      force_r <= force_nxt;
      en_r    <= en_nxt;
      men_r   <= men_nxt;
      pend_r  <= pend_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // Read data and interrupt edges
  always_comb begin
    res       = '0;
    res.line  = flag_nxt;
    res.raise = op.exec && flag_nxt && !flag_r;
    res.drop  = op.exec && !flag_nxt && flag_r;
    if (op.exec && (op.mode == MODE_READ)) begin
      if (op.offset == OFF_PRIORITY) begin
        res.rdata = prio_r;
      end else if (op.offset == OFF_DICR) begin
        res.rdata = {flag_r, pend_r, men_r, en_r, force_r, 9'd0, spare_r};
      end
    end
  end

endmodule

FILE: hw/rtl/dma_channel_register_block_top.sv
`timescale 1ns / 1ps

// Channel  | Handshake         | Payload
// ---------+-------------------+-----------------------------------------------
// in_      | in_valid/in_ready | mode, offset, write_data, event_channel
// out_     | out_valid/out_ready | read_data, channel_started, slice_cancel,
//          |                   | irq_line, irq_raise, irq_drop
//
// An item is captured in the input register, decoded against the register
// file and lands in the result register; one item per cycle is sustained
// while the result is not stalled. Synchronous active-low reset returns the
// valid flags and the register-file state to their reset values; the payload
// registers are not reset. A stalled result holds the input register; a new
// item is still taken in the same cycle the pending one moves on.

module dma_channel_register_block_top #(
  parameter int NUM_CHANNELS = dcr_pkg::DEF_NUM_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [6:0]  in_offset,
  input  logic [31:0] in_write_data,
  input  logic [2:0]  in_event_channel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_channel_started,
  output logic        out_slice_cancel,
  output logic        out_irq_line,
  output logic        out_irq_raise,
  output logic        out_irq_drop
);
  import dcr_pkg::*;

  logic          s1_valid_r;
  logic [1:0]    s1_mode_r;
  logic [6:0]    s1_offset_r;
  logic [31:0]   s1_wdata_r;
  logic [2:0]    s1_evch_r;
  logic          out_valid_r;
  logic          advance;
  dcr_op_t       op;
  dcr_chan_res_t chan_res;
  dcr_irq_res_t  irq_res;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r   <= in_mode;
      s1_offset_r <= in_offset;
      s1_wdata_r  <= in_write_data;
      s1_evch_r   <= in_event_channel;
    end
  end

  assign op.exec   = advance;
  assign op.mode   = s1_mode_r;
  assign op.offset = s1_offset_r;
  assign op.wdata  = s1_wdata_r;
  assign op.evch   = s1_evch_r;

  dcr_chan_regs #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_chan (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .res   (chan_res)
  );

  dcr_irq_regs #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_irq (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .res   (irq_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data       <= chan_res.rdata | irq_res.rdata;
      out_channel_started <= chan_res.started;
      out_slice_cancel    <= chan_res.cancel;
      out_irq_line        <= irq_res.line;
      out_irq_raise       <= irq_res.raise;
      out_irq_drop        <= irq_res.drop;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_no_start_and_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_channel_started && out_slice_cancel))
    else $error("channel_started and slice_cancel both set");

  a_raise_sets_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_irq_raise) |-> (out_irq_line && !out_irq_drop))
    else $error("irq_raise without irq_line");

  a_drop_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_irq_drop) |-> !out_irq_line)
    else $error("irq_drop with irq_line high");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_bus_error_raises_line: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_mode_r == MODE_ERROR)) |=> (out_valid_r && out_irq_line))
    else $error("bus error did not drive the interrupt line");

endmodule
